/* hw/rtl/spc_pkg.sv */
// Shared types, constants and the position-to-segment lookup for the palette crossfade block.
package spc_pkg;

   localparam int NUM_SEG   = 55;    // palette entries, segment indices 1..55
   localparam int SEG_DEPTH = 512;   // 16 rows x 32 columns
   localparam int SEG_W     = 6;
   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int ADDR_W    = 9;
   localparam int SLOT_W    = 6;

   localparam logic [SEG_W-1:0] SEG_NONE = 6'd0;
   localparam logic [SEG_W-1:0] SEG_TOP  = 6'd1;
   localparam logic [SEG_W-1:0] SEG_E0   = 6'd54;
   localparam logic [SEG_W-1:0] SEG_E1   = 6'd55;
   localparam logic [SEG_W-1:0] BASE_A   = 6'd2;
   localparam logic [SEG_W-1:0] BASE_B   = 6'd15;
   localparam logic [SEG_W-1:0] BASE_C   = 6'd28;
   localparam logic [SEG_W-1:0] BASE_D   = 6'd41;

   localparam logic [3:0] BLANK_ROW = 4'd5;

   // row pairs, indexed by row[3:1]
   localparam logic [2:0] ROWS_P = 3'd3;
   localparam logic [2:0] ROWS_Q = 3'd4;
   localparam logic [2:0] ROWS_R = 3'd5;
   localparam logic [2:0] ROWS_S = 3'd6;
   localparam logic [2:0] ROWS_T = 3'd7;

   typedef enum logic [1:0] {
      KIND_SET  = 2'd0,
      KIND_LOAD = 2'd1,
      KIND_TICK = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_SEG,
      ST_MIX,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic sweep_clear;   // clearing pass step
      logic sweep_copy;    // palette rotate step
      logic do_set;
      logic do_load;
      logic do_tick;
      logic do_read;       // segment store read
      logic pal_read;
      logic mix;
      logic div_step;
      logic out_load;
   } spc_cmd_type;

   typedef struct packed {
      logic reload;        // countdown at zero
      logic clear_last;
      logic copy_last;
   } spc_status_type;

   // Fixed segment map of the panel; row 5 is blank.
   function automatic logic [SEG_W-1:0] seg_rom_lookup(input logic [3:0] row,
                                                       input logic [4:0] col);
      logic             in_grp;
      logic [SEG_W-1:0] base;
      logic [1:0]       pair;
      logic             k_ok;
      logic [3:0]       k;
      logic [SEG_W-1:0] seg;
      in_grp = 1'b1;
      base   = SEG_NONE;
      pair   = 2'd0;
      k_ok   = 1'b1;
      k      = 4'd0;
      unique case (col)
         5'd1, 5'd2:   begin base = BASE_A; pair = 2'd0; end
         5'd3, 5'd4:   begin base = BASE_A; pair = 2'd1; end
         5'd5, 5'd6:   begin base = BASE_A; pair = 2'd2; end
         5'd8, 5'd9:   begin base = BASE_B; pair = 2'd0; end
         5'd10, 5'd11: begin base = BASE_B; pair = 2'd1; end
         5'd12, 5'd13: begin base = BASE_B; pair = 2'd2; end
         5'd18, 5'd19: begin base = BASE_C; pair = 2'd0; end
         5'd20, 5'd21: begin base = BASE_C; pair = 2'd1; end
         5'd22, 5'd23: begin base = BASE_C; pair = 2'd2; end
         5'd25, 5'd26: begin base = BASE_D; pair = 2'd0; end
         5'd27, 5'd28: begin base = BASE_D; pair = 2'd1; end
         5'd29, 5'd30: begin base = BASE_D; pair = 2'd2; end
         default:      in_grp = 1'b0;
      endcase
      unique case ({row[3:1], pair})
         {ROWS_P, 2'd0}: k = 4'd0;
         {ROWS_P, 2'd1}: k = 4'd1;
         {ROWS_P, 2'd2}: k = 4'd2;
         {ROWS_Q, 2'd0}: k = 4'd11;
         {ROWS_Q, 2'd2}: k = 4'd3;
         {ROWS_R, 2'd0}: k = 4'd10;
         {ROWS_R, 2'd1}: k = 4'd12;
         {ROWS_R, 2'd2}: k = 4'd4;
         {ROWS_S, 2'd0}: k = 4'd9;
         {ROWS_S, 2'd2}: k = 4'd5;
         {ROWS_T, 2'd0}: k = 4'd8;
         {ROWS_T, 2'd1}: k = 4'd7;
         {ROWS_T, 2'd2}: k = 4'd6;
         default:        k_ok = 1'b0;
      endcase
      if (row < BLANK_ROW) begin
         seg = SEG_TOP;
      end else if (row == BLANK_ROW) begin
         seg = SEG_NONE;
      end else if (in_grp && k_ok) begin
         seg = base + {2'b00, k};
      end else if ((col == 5'd15 || col == 5'd16) && row[3:1] == ROWS_Q) begin
         seg = SEG_E0;
      end else if ((col == 5'd15 || col == 5'd16) && row[3:1] == ROWS_S) begin
         seg = SEG_E1;
      end else begin
         seg = SEG_NONE;
      end
      return seg;
   endfunction

endpackage

/* hw/rtl/spc_ctrl.sv */
// Controller state machine: handshakes, clearing pass, palette rotate and read sequencing.
module spc_ctrl
   import spc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_kind,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  spc_status_type status,
   output spc_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind;

   assign kind      = kind_type'(req_kind);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (kind)
                  KIND_SET:  cmd.do_set  = 1'b1;
                  KIND_LOAD: cmd.do_load = 1'b1;
                  KIND_TICK: begin
                     cmd.do_tick = 1'b1;
                     if (status.reload) state_in = ST_COPY;
                  end
                  KIND_READ: begin
                     cmd.do_read = 1'b1;
                     state_in    = ST_SEG;
                  end
                  default: ;
               endcase
            end
         end
         ST_COPY: begin
            cmd.sweep_copy = 1'b1;
            if (status.copy_last) state_in = ST_IDLE;
         end
         ST_SEG: begin
            cmd.pal_read = 1'b1;
            state_in     = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

/* hw/rtl/spc_datapath.sv */
// Datapath: segment store, three palettes, fade countdown, mixer and divider, output register.
module spc_datapath
   import spc_pkg::*;
#(
   parameter int FADE_PERIOD = 500
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  spc_cmd_type          cmd,
   output spc_status_type       status,
   input  logic [3:0]           req_row,
   input  logic [4:0]           req_column,
   input  logic                 req_pixel_on,
   input  logic [SLOT_W-1:0]    req_palette_slot,
   input  logic [COLOR_W-1:0]   req_new_color,
   output logic [COLOR_W-1:0]   rsp_pixel_color
);

   localparam int CW          = $clog2(FADE_PERIOD);
   localparam int PW          = CW + CHAN_W;
   localparam int PROD_W      = 2 * PW + 2;
   localparam int RECIP_SHIFT = PW + CW;
   localparam logic [CW-1:0] PERIOD_MAX = CW'(FADE_PERIOD - 1);
   // ceil(2^RECIP_SHIFT / (FADE_PERIOD-1)): exact floor quotient for any sum below 2^PW
   localparam logic [PW+1:0] RECIP =
      (PW+2)'(((64'd1 << RECIP_SHIFT) + 64'(FADE_PERIOD - 2)) / 64'(FADE_PERIOD - 1));

   logic [SEG_W-1:0]   seg_mem     [0:SEG_DEPTH-1];
   logic [COLOR_W-1:0] old_mem     [0:NUM_SEG-1];
   logic [COLOR_W-1:0] new_mem     [0:NUM_SEG-1];
   logic [COLOR_W-1:0] pending_mem [0:NUM_SEG-1];

   logic [ADDR_W-1:0]  sweep_cnt_ff;
   logic [CW-1:0]      countdown_ff;
   logic               copy_wr_en_ff;
   logic [SLOT_W-1:0]  copy_wr_addr_ff;
   logic [SEG_W-1:0]   seg_rd_ff;
   logic [COLOR_W-1:0] old_rd_ff;
   logic [COLOR_W-1:0] new_rd_ff;
   logic [COLOR_W-1:0] pend_rd_ff;
   logic               black_ff;
   logic [PW-1:0]      sum_ff [3];
   logic [CHAN_W-1:0]  quo_ff [3];
   logic [COLOR_W-1:0] pixel_color_ff;

   logic [ADDR_W-1:0]  pix_addr;
   logic               clear_pal;
   logic [SLOT_W-1:0]  pal_addr;
   logic [SLOT_W-1:0]  seg_slot;
   logic [CW-1:0]      weight_new;
   logic [PW-1:0]      mix_sum    [3];
   logic [PROD_W-1:0]  recip_prod [3];

   assign pix_addr  = {req_row, req_column};
   assign clear_pal = cmd.sweep_clear && (sweep_cnt_ff < ADDR_W'(NUM_SEG));
   assign seg_slot  = (seg_rd_ff == SEG_NONE) ? '0 : seg_rd_ff - 1'b1;
   assign pal_addr  = cmd.sweep_copy ? sweep_cnt_ff[SLOT_W-1:0] : seg_slot;
   assign weight_new = PERIOD_MAX - countdown_ff;

   assign status.reload     = (countdown_ff == '0);
   assign status.clear_last = (sweep_cnt_ff == ADDR_W'(SEG_DEPTH - 1));
   assign status.copy_last  = (sweep_cnt_ff == ADDR_W'(NUM_SEG - 1));
   assign rsp_pixel_color   = pixel_color_ff;

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff  <= '0;
         countdown_ff  <= '0;
         copy_wr_en_ff <= 1'b0;
      end else begin
         if ((cmd.sweep_clear && status.clear_last) || (cmd.sweep_copy && status.copy_last)) begin
            sweep_cnt_ff <= '0;
         end else if (cmd.sweep_clear || cmd.sweep_copy) begin
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         end
         if (cmd.do_tick) begin
            countdown_ff <= status.reload ? PERIOD_MAX : countdown_ff - 1'b1;
         end
         copy_wr_en_ff <= cmd.sweep_copy;
      end
   end

   // segment store
   always_ff @(posedge clock) begin
      if (cmd.sweep_clear) begin
         seg_mem[sweep_cnt_ff] <= SEG_NONE;
      end else if (cmd.do_set) begin
         seg_mem[pix_addr] <= req_pixel_on ? seg_rom_lookup(req_row, req_column) : SEG_NONE;
      end
      if (cmd.do_read) begin
         seg_rd_ff <= seg_mem[pix_addr];
      end
   end

   // palettes: rotate is a read of entry i then a write of it in the following cycle
   always_ff @(posedge clock) begin
      if (clear_pal) begin
         old_mem[sweep_cnt_ff[SLOT_W-1:0]] <= '0;
      end else if (copy_wr_en_ff) begin
         old_mem[copy_wr_addr_ff] <= new_rd_ff;
      end
      if (cmd.pal_read) begin
         old_rd_ff <= old_mem[pal_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clear_pal) begin
         new_mem[sweep_cnt_ff[SLOT_W-1:0]] <= '0;
      end else if (copy_wr_en_ff) begin
         new_mem[copy_wr_addr_ff] <= pend_rd_ff;
      end
      if (cmd.pal_read || cmd.sweep_copy) begin
         new_rd_ff <= new_mem[pal_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clear_pal) begin
         pending_mem[sweep_cnt_ff[SLOT_W-1:0]] <= '0;
      end else if (cmd.do_load && req_palette_slot < SLOT_W'(NUM_SEG)) begin
         pending_mem[req_palette_slot] <= req_new_color;
      end
      if (cmd.sweep_copy) begin
         pend_rd_ff <= pending_mem[pal_addr];
      end
   end

   always_ff @(posedge clock) begin
      copy_wr_addr_ff <= pal_addr;
      if (cmd.pal_read) begin
         black_ff <= (seg_rd_ff == SEG_NONE);
      end
   end

   // weighted sum, then divide by FADE_PERIOD-1 as a PW x (PW+2) reciprocal multiply
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_sum[c]    = PW'(countdown_ff) * PW'(old_rd_ff[c*CHAN_W +: CHAN_W])
                       + PW'(weight_new)   * PW'(new_rd_ff[c*CHAN_W +: CHAN_W]);
         recip_prod[c] = PROD_W'(sum_ff[c]) * PROD_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.mix) begin
            sum_ff[c] <= mix_sum[c];
         end
         if (cmd.div_step) begin
            quo_ff[c] <= recip_prod[c][RECIP_SHIFT +: CHAN_W];
         end
      end
      if (cmd.out_load) begin
         pixel_color_ff <= black_ff ? '0 : {quo_ff[2], quo_ff[1], quo_ff[0]};
      end
   end

endmodule

/* hw/rtl/segment_palette_crossfade.sv */
// Segment palette crossfade: top level joining the controller and the datapath.
// Reset starts a clearing pass of the segment store and palettes, req_ready low.
// Set, load and ordinary tick items complete on acceptance; a tick that finds the countdown at zero
// also rotates the palettes, 55 entries through one memory port each.
// A read runs in steps: store read, palette read, mix, reciprocal divide, output load.
// rsp_valid rises with the output load and holds until taken; a later read waits on it.
module segment_palette_crossfade
   import spc_pkg::*;
#(
   parameter int FADE_PERIOD = 500
)
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [3:0]          req_row,
   input  logic [4:0]          req_column,
   input  logic                req_pixel_on,
   input  logic [SLOT_W-1:0]   req_palette_slot,
   input  logic [COLOR_W-1:0]  req_new_color,
   // response channel, only read items produce a transfer
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COLOR_W-1:0]  rsp_pixel_color
);

   spc_cmd_type    cmd;
   spc_status_type status;

   // sequencing: decodes the kind, runs sweeps and the read steps, owns rsp_valid
   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic; the output payload register lives here
   spc_datapath #(
      .FADE_PERIOD (FADE_PERIOD)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_row          (req_row),
      .req_column       (req_column),
      .req_pixel_on     (req_pixel_on),
      .req_palette_slot (req_palette_slot),
      .req_new_color    (req_new_color),
      .rsp_pixel_color  (rsp_pixel_color)
   );

endmodule
